// ----- rtl/core/sdf_pkg.sv -----
`default_nettype none

package sdf_pkg;

	localparam int MAX_DIGITS  = 10;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int DIG_IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CONV_CNT_W  = $clog2(VALUE_WIDTH + 1);
	localparam int IN_DATA_W   = ((VALUE_WIDTH + 2 * COUNT_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/signed_decimal_formatter_core.sv -----
// Channel  Direction  Payload (lowest bit up)                          End marker
// s_*      in         tdata: value[31:0] digit_count[35:32] point_pos[39:36]  none
// m_*      out        tdata: character[7:0]                            tlast = last
//
// An item is taken in the idle state, converted by the chain of digit cells (one
// magnitude bit per cycle), then sent as 1 to 12 characters, one per cycle while
// m_tready is high.
// Reset clears the control state and the output valid; no clearing pass is needed.
// A stall on the output holds the current character and pauses the run.
`default_nettype none

module signed_decimal_formatter_core
	import sdf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,  // value, digit_count, point_pos
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [CHAR_W-1:0]         m_tdata,  // character
	output logic                      m_tlast   // last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CONV_CNT_W-1:0]  conv_cnt_q;
	logic [COUNT_W-1:0]     idx_q;
	logic [COUNT_W-1:0]     point_q;
	logic                   neg_q;
	logic                   sign_done_q;
	logic                   pt_done_q;
	logic                   m_tvalid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic [COUNT_W-1:0]     count_in;
	logic [COUNT_W-1:0]     count_sat;
	logic [COUNT_W-1:0]     point_in;
	logic                   slot_free;
	chain_ctrl_t            ctrl;
	digit_t                 digits [MAX_DIGITS];
	digit_t                 cur_digit;

	assign raw       = s_tdata[VALUE_WIDTH-1:0];
	assign count_in  = s_tdata[VALUE_WIDTH +: COUNT_W];
	assign point_in  = s_tdata[VALUE_WIDTH + COUNT_W +: COUNT_W];
	assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
	assign count_sat = (int'(count_in) > MAX_DIGITS) ? COUNT_W'(MAX_DIGITS) : count_in;

	assign s_tready  = (state_q == ST_IDLE);
	assign slot_free = !m_tvalid_q || m_tready;

	assign ctrl.load  = (state_q == ST_IDLE) && s_tvalid;
	assign ctrl.shift = (state_q == ST_CONV);

	sdf_bcd_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.magnitude(magnitude),
		.digits   (digits)
	);

	assign cur_digit = digits[DIG_IDX_W'(idx_q - COUNT_W'(1))];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			conv_cnt_q  <= '0;
			idx_q       <= '0;
			point_q     <= '0;
			neg_q       <= 1'b0;
			sign_done_q <= 1'b0;
			pt_done_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q       <= raw[VALUE_WIDTH-1];
						idx_q       <= count_sat;
						point_q     <= point_in;
						conv_cnt_q  <= CONV_CNT_W'(VALUE_WIDTH);
						sign_done_q <= 1'b0;
						pt_done_q   <= 1'b0;
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					conv_cnt_q <= conv_cnt_q - 1'b1;
					if (conv_cnt_q == CONV_CNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						priority if (!sign_done_q) begin
							sign_done_q <= 1'b1;
							if (idx_q == '0) begin
								state_q <= ST_IDLE;
							end
						end else if (idx_q == point_q && !pt_done_q) begin
							pt_done_q <= 1'b1;
						end else begin
							idx_q     <= idx_q - 1'b1;
							pt_done_q <= 1'b0;
							if (idx_q == COUNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			priority if (!sign_done_q) begin
				char_q <= neg_q ? CH_MINUS : CH_SPACE;
				last_q <= (idx_q == '0);
			end else if (idx_q == point_q && !pt_done_q) begin
				char_q <= CH_POINT;
				last_q <= 1'b0;
			end else begin
				char_q <= CH_ZERO + {4'b0000, cur_digit};
				last_q <= (idx_q == COUNT_W'(1));
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/sdf_digit_cell.sv -----
`default_nettype none

module sdf_digit_cell
	import sdf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire chain_ctrl_t ctrl,
	input  wire logic        cin,
	output logic             cout,
	output digit_t           digit
);

	digit_t     digit_q;
	digit_t     digit_nxt;
	logic [4:0] sum;

	// Each shift cycle the cell doubles its digit and adds the bit from below.
	always_comb begin
		sum = {digit_q, 1'b0} + {4'b0000, cin};
		if (sum >= 5'd10) begin
			digit_nxt = 4'(sum - 5'd10);
			cout      = 1'b1;
		end else begin
			digit_nxt = sum[3:0];
			cout      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.load) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= digit_nxt;
		end
	end

	assign digit = digit_q;

endmodule

`default_nettype wire

// ----- rtl/core/sdf_bcd_chain.sv -----
`default_nettype none

module sdf_bcd_chain
	import sdf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire chain_ctrl_t            ctrl,
	input  wire logic [VALUE_WIDTH-1:0] magnitude,
	output digit_t                      digits [MAX_DIGITS]
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   carry [MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= magnitude;
		end else if (ctrl.shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign carry[0] = mag_q[VALUE_WIDTH-1];

	// The carry out of the top cell is dropped, which keeps only the low digits.
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		if (i < MAX_DIGITS - 1) begin : g_mid
			sdf_digit_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.cin   (carry[i]),
				.cout  (carry[i+1]),
				.digit (digits[i])
			);
		end else begin : g_top
			sdf_digit_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.cin   (carry[i]),
				.cout  (),
				.digit (digits[i])
			);
		end
	end

endmodule

`default_nettype wire
